// File: rtl/smooth_rdf_histogram_accumulator_core_assert.svh
// assertion macros for the histogram accumulator back end rtl
`ifndef SMOOTH_RDF_HISTOGRAM_ACCUMULATOR_CORE_ASSERT_SVH
`define SMOOTH_RDF_HISTOGRAM_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRHA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("srha assertion failed");
`define SRHA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("srha reset assertion failed");
`else
`define SRHA_ASSERT(lbl, prop)
`define SRHA_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/srha_pkg.sv
// shared types and constants for the histogram accumulator
package srha_pkg;
    localparam int MAX_STEPS_DEF    = 64;
    localparam int CLASH_LEVELS_DEF = 8;
    localparam int SIGN_CLASSES     = 3;
    localparam int IN_DATA_W        = 72;
    localparam int OUT_DATA_W       = 56;
    localparam int MAG_W            = 31;
    localparam int CNT_W            = 6;

    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [1:0] CFG_STEPS     = 2'd1;
    localparam logic [1:0] CFG_CLASH_MAX = 2'd2;
    localparam logic [1:0] CFG_ROOT      = 2'd3;

    localparam logic [1:0] SC_NONPOS = 2'd0;
    localparam logic [1:0] SC_POS    = 2'd1;
    localparam logic [1:0] SC_NEG    = 2'd2;

    typedef struct packed {
        logic [14:0] bin_width;
        logic [6:0]  steps_in_use;
        logic [2:0]  max_clash;
        logic        root_mode;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [15:0]       distance;
        logic [MAG_W-1:0]  mag;
        logic [1:0]        sclass;
        logic [7:0]        clash;
        logic [10:0]       rindex;
    } t_work;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;
endpackage

// File: rtl/smooth_rdf_histogram_accumulator_core.sv
// Smoothed distance histogram accumulator. After reset the histogram
// (MAX_STEPS*3*CLASH_LEVELS bins, 1536 by default) is swept clear, one bin
// per cycle, and no beat is taken during that sweep. An accumulate beat then
// runs the shared one-bit-per-cycle divider, first for the bin number and then
// for the interpolation weight, plus up to two read-modify-writes on the bin
// memory; root mode first runs the two-bits-per-cycle square root. A read beat
// clears the bin it returns. Accumulate beats with a zero product are dropped
// at the input. A two-entry queue lets the input keep taking beats while the
// sequencer works.
module smooth_rdf_histogram_accumulator_core
    import srha_pkg::*;
#(
    parameter int MAX_STEPS    = MAX_STEPS_DEF,
    parameter int CLASH_LEVELS = CLASH_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pair_distance, first_property, second_property, clash_count, read_index
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bin_number, bin_contents
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);
    t_cfg      r_cfg;
    t_back_ctl w_ctl;
    logic      w_q_valid;
    t_work     w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_width    <= 15'd256;
            r_cfg.steps_in_use <= 7'd12;
            r_cfg.max_clash    <= 3'd2;
            r_cfg.root_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_SIZE: r_cfg.bin_width    <= i_cfg_data;
                CFG_STEPS:     r_cfg.steps_in_use <= i_cfg_data[6:0];
                CFG_CLASH_MAX: r_cfg.max_clash    <= i_cfg_data[2:0];
                CFG_ROOT:      r_cfg.root_mode    <= i_cfg_data[0];
                default:       r_cfg.root_mode    <= r_cfg.root_mode;
            endcase
        end
    end

    srha_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_ctl         (w_ctl),
        .o_q_valid     (w_q_valid),
        .o_q_data      (w_q_data)
    );

    srha_back #(
        .MAX_STEPS    (MAX_STEPS),
        .CLASH_LEVELS (CLASH_LEVELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_data),
        .o_ctl         (w_ctl),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );
endmodule

// File: rtl/srha_front.sv
// front end: accepts beats, forms product and sign class, queues work
module srha_front
    import srha_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic            s_axis_tuser,
    input  t_back_ctl       i_ctl,
    output logic            o_q_valid,
    output t_work           o_q_data
);
    t_work       r_ent [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic signed [15:0] w_a, w_b;
    logic signed [31:0] w_prod;
    logic        w_acc, w_keep, w_push, w_pop;
    t_work       w_new;

    assign w_a    = s_axis_tdata[31:16];
    assign w_b    = s_axis_tdata[47:32];
    assign w_prod = w_a * w_b;

    always_comb begin
        w_new.cmd      = s_axis_tuser;
        w_new.distance = s_axis_tdata[15:0];
        w_new.clash    = s_axis_tdata[55:48];
        w_new.rindex   = s_axis_tdata[66:56];
        w_new.mag      = w_prod[31] ? MAG_W'(-w_prod) : MAG_W'(w_prod);
        if (w_prod[31]) begin
            w_new.sclass = SC_NEG;
        end else if (w_a > 16'sd0) begin
            w_new.sclass = SC_POS;
        end else begin
            w_new.sclass = SC_NONPOS;
        end
    end

    assign s_axis_tready = (r_cnt != 2'd2) && !i_ctl.clearing;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    // accumulate beats with a zero product add nothing and are dropped here
    assign w_keep = (s_axis_tuser == CMD_READ) || (w_prod != 32'sd0);
    assign w_push = w_acc && w_keep;
    assign w_pop  = i_ctl.pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_ent[r_wp] <= w_new;
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_ent[r_rp];
endmodule

// File: rtl/srha_back.sv
// back end: sqrt and divide sequencer, histogram memory, read and clear
module srha_back
    import srha_pkg::*;
#(
    parameter int MAX_STEPS    = MAX_STEPS_DEF,
    parameter int CLASH_LEVELS = CLASH_LEVELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_q_valid,
    input  t_work           i_q_data,
    output t_back_ctl       o_ctl,
    input  logic            m_axis_tready,
    output logic            m_axis_tvalid,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);
`include "smooth_rdf_histogram_accumulator_core_assert.svh"
    localparam int BIN_COUNT = MAX_STEPS * SIGN_CLASSES * CLASH_LEVELS;
    localparam int AW        = $clog2(BIN_COUNT);
    localparam int SW        = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SQRT = 4'd2;
    localparam logic [3:0] S_SQD  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_SEL  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_AMT  = 4'd7;
    localparam logic [3:0] S_RD   = 4'd8;
    localparam logic [3:0] S_WR   = 4'd9;
    localparam logic [3:0] S_RDC  = 4'd10;
    localparam logic [3:0] S_RDW  = 4'd11;

    logic [3:0]       r_state;
    logic [AW-1:0]    r_clr;
    logic             r_out_valid;
    logic [10:0]      r_out_num;
    logic [39:0]      r_out_val;

    t_work            r_work;
    logic [MAG_W-1:0] r_mag;
    logic [2:0]       r_clash;
    logic [CNT_W-1:0] r_cnt;
    logic             r_phase;
    logic [45:0]      r_dvd;
    logic [45:0]      r_quo;
    logic [14:0]      r_rem;
    logic [47:0]      r_sv;
    logic [25:0]      r_srem;
    logic [23:0]      r_root;
    logic             r_split;
    logic [14:0]      r_fac;
    logic [AW-1:0]    r_base;
    logic [SW-1:0]    r_qsel;
    logic [AW-1:0]    r_cur;
    logic [MAG_W-1:0] r_amt0, r_amt1;
    logic             r_two;
    logic             r_oob;

    logic [39:0]      r_mem [BIN_COUNT];
    logic [39:0]      r_rdata;

    logic [14:0]      w_step;
    logic [SW-1:0]    w_steps;
    logic [2:0]       w_clash;
    logic [2:0]       w_clash_top;
    logic [15:0]      w_rem2;
    logic             w_ge;
    logic [27:0]      w_srem2, w_trial;
    logic             w_sge;
    logic [15:0]      w_q;
    logic             w_split;
    logic [31:0]      w_edge;
    logic             w_out_free;
    logic [40:0]      w_sum;
    logic             w_we;
    logic [AW-1:0]    w_wa, w_ra;
    logic [39:0]      w_wd;

    assign w_step  = (i_cfg.bin_width == 15'd0) ? 15'd1 : i_cfg.bin_width;
    assign w_steps = (i_cfg.steps_in_use == 7'd0) ? SW'(1) :
                     (32'(i_cfg.steps_in_use) > MAX_STEPS) ? SW'(MAX_STEPS) :
                     SW'(i_cfg.steps_in_use);
    assign w_clash_top = (32'(i_cfg.max_clash) > CLASH_LEVELS - 1) ?
                         3'(CLASH_LEVELS - 1) : i_cfg.max_clash;
    assign w_clash = (i_q_data.clash > 8'(w_clash_top)) ? w_clash_top :
                     i_q_data.clash[2:0];

    // shared restoring divider, one quotient bit per cycle
    assign w_rem2 = {r_rem, r_dvd[45]};
    assign w_ge   = w_rem2 >= {1'b0, w_step};

    // digit-by-digit square root, two radicand bits per cycle
    assign w_srem2 = {r_srem, r_sv[47:46]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = w_srem2 >= w_trial;

    assign w_q     = r_quo[15:0];
    assign w_split = ({1'b0, w_q} + 17'd1) < 17'(w_steps);
    assign w_edge  = 32'(w_steps) * 32'(w_step);

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_sum = {1'b0, r_rdata} + 41'(r_amt0);

    always_comb begin
        w_we = 1'b0;
        w_wa = r_cur;
        w_wd = w_sum[40] ? 40'hFF_FFFF_FFFF : w_sum[39:0];
        w_ra = r_cur;
        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                w_wa = r_clr;
                w_wd = 40'd0;
            end
            S_WR: begin
                w_we = 1'b1;
            end
            S_RDC: begin
                w_ra = AW'(r_work.rindex);
            end
            S_RDW: begin
                // keep the read data on the requested bin while the output stalls
                w_ra = AW'(r_work.rindex);
                w_we = w_out_free && !r_oob;
                w_wa = AW'(r_work.rindex);
                w_wd = 40'd0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rdata <= r_mem[w_ra];
    end

    assign o_ctl.pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_ctl.clearing = (r_state == S_CLR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == S_RDW) && w_out_free) ? 1'b1 :
                           (r_out_valid && !m_axis_tready);
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(BIN_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_data.cmd == CMD_READ) begin
                            r_state <= (32'(i_q_data.rindex) < BIN_COUNT) ? S_RDC : S_RDW;
                        end else if (i_cfg.root_mode) begin
                            r_state <= S_SQRT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_SQRT: if (r_cnt == CNT_W'(1)) r_state <= S_SQD;
                S_SQD:  r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == CNT_W'(1)) r_state <= r_phase ? S_AMT : S_SEL;
                end
                S_SEL: begin
                    if (!w_split && (w_edge <= 32'(r_work.distance))) r_state <= S_IDLE;
                    else r_state <= S_MUL;
                end
                S_MUL: r_state <= S_DIV;
                S_AMT: r_state <= S_RD;
                S_RD:  r_state <= S_WR;
                S_WR:  r_state <= r_two ? S_RD : S_IDLE;
                S_RDC: r_state <= S_RDW;
                S_RDW: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_work  <= i_q_data;
                r_mag   <= i_q_data.mag;
                r_clash <= w_clash;
                r_oob   <= !(32'(i_q_data.rindex) < BIN_COUNT);
                r_sv    <= {1'b0, i_q_data.mag, 16'd0};
                r_srem  <= '0;
                r_root  <= '0;
                r_dvd   <= {i_q_data.distance, 30'd0};
                r_quo   <= '0;
                r_rem   <= '0;
                r_phase <= 1'b0;
                r_cnt   <= i_cfg.root_mode ? CNT_W'(24) : CNT_W'(16);
            end
            S_SQRT: begin
                r_sv   <= {r_sv[45:0], 2'b00};
                r_srem <= w_sge ? 26'(w_srem2 - w_trial) : 26'(w_srem2);
                r_root <= {r_root[22:0], w_sge};
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            S_SQD: begin
                r_mag <= MAG_W'(r_root);
                r_cnt <= CNT_W'(16);
            end
            S_DIV: begin
                r_dvd <= {r_dvd[44:0], 1'b0};
                r_quo <= {r_quo[44:0], w_ge};
                r_rem <= w_ge ? 15'(w_rem2 - {1'b0, w_step}) : 15'(w_rem2);
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_SEL: begin
                r_split <= w_split;
                r_fac   <= w_split ? r_rem : 15'(w_edge - 32'(r_work.distance));
                r_qsel  <= w_split ? SW'(w_q) : SW'(w_steps - SW'(1));
                r_base  <= AW'(32'(r_clash) * 32'(w_steps) * SIGN_CLASSES
                               + 32'(r_work.sclass));
            end
            S_MUL: begin
                r_dvd   <= 46'(r_mag) * 46'(r_fac);
                r_quo   <= '0;
                r_rem   <= '0;
                r_cur   <= AW'(32'(r_base) + 32'(r_qsel) * SIGN_CLASSES);
                r_phase <= 1'b1;
                r_cnt   <= CNT_W'(46);
            end
            S_AMT: begin
                // split case: lower bin takes what the upper one does not
                r_amt0 <= r_split ? (r_mag - r_quo[MAG_W-1:0]) : r_quo[MAG_W-1:0];
                r_amt1 <= r_quo[MAG_W-1:0];
                r_two  <= r_split;
            end
            S_WR: begin
                r_cur  <= r_cur + AW'(SIGN_CLASSES);
                r_amt0 <= r_amt1;
                r_two  <= 1'b0;
            end
            S_RDW: begin
                if (w_out_free) begin
                    r_out_num <= r_work.rindex;
                    r_out_val <= r_oob ? 40'd0 : r_rdata;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_val, r_out_num};

    `SRHA_ASSERT(a_no_out_in_clear, (r_state == S_CLR) |-> !r_out_valid)
    `SRHA_ASSERT(a_wr_in_range, w_we |-> (32'(w_wa) < BIN_COUNT))
    `SRHA_ASSERT(a_wr_after_rd, (r_state == S_WR) |-> ($past(r_state) == S_RD))
    `SRHA_ASSERT(a_no_pop_busy, o_ctl.pop |-> (r_state == S_IDLE))
    `SRHA_ASSERT_RST(a_reset_clears, !i_rst_n |=> (r_state == S_CLR) && !r_out_valid)
endmodule

// File: dv/smooth_rdf_histogram_accumulator_core_checker.sv
// checker for the histogram accumulator: mirrors the bins and scores every read beat
`timescale 1ns / 100ps
module smooth_rdf_histogram_accumulator_core_checker
    import srha_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [14:0]           i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    o_fail_count,
    output int                    o_reads_pending
);
    localparam int BINS = MAX_STEPS_DEF * SIGN_CLASSES * CLASH_LEVELS_DEF;
    localparam logic [39:0] BIN_FULL = 40'hFF_FFFF_FFFF;

    typedef struct {
        logic [10:0] bin_number;
        logic [39:0] contents;
    } t_bin_read;

    logic [39:0] bin_store [BINS];
    t_bin_read   pending_reads [$];
    t_cfg        shadow_cfg;

    function automatic logic [63:0] root_of(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    task automatic add_bin(logic [63:0] idx, logic [63:0] amount);
        logic [63:0] sum;
        if (idx < BINS) begin
            sum = bin_store[idx] + amount;
            bin_store[idx] = (sum > BIN_FULL) ? BIN_FULL : sum[39:0];
        end
    endtask

    task automatic accumulate_pair(logic [IN_DATA_W-1:0] d);
        logic [63:0] pair_dist, clash, mag, step, steps, clash_max, base, q, r, high, edge_d;
        logic signed [31:0] a, b;
        logic signed [63:0] prod;
        logic [1:0] sclass;
        pair_dist = d[15:0];
        a = $signed(d[31:16]);
        b = $signed(d[47:32]);
        clash = d[55:48];
        prod = a * b;
        sclass = (a > 0) ? SC_POS : SC_NONPOS;
        step = (shadow_cfg.bin_width == 0) ? 1 : shadow_cfg.bin_width;
        steps = shadow_cfg.steps_in_use;
        clash_max = shadow_cfg.max_clash;
        if (prod != 0) begin
            if (prod < 0) begin
                mag = -prod;
                sclass = SC_NEG;
            end else begin
                mag = prod;
            end
            if (shadow_cfg.root_mode) mag = root_of(mag << 16);
            if (steps == 0) steps = 1;
            if (steps > MAX_STEPS_DEF) steps = MAX_STEPS_DEF;
            if (clash_max > CLASH_LEVELS_DEF - 1) clash_max = CLASH_LEVELS_DEF - 1;
            if (clash > clash_max) clash = clash_max;
            base = clash * steps * SIGN_CLASSES + sclass;
            q = pair_dist / step;
            r = pair_dist - q * step;
            if (q + 1 < steps) begin
                high = (mag * r) / step;
                add_bin(base + SIGN_CLASSES * q, mag - high);
                add_bin(base + SIGN_CLASSES * (q + 1), high);
            end else begin
                edge_d = steps * step;
                if (edge_d > pair_dist)
                    add_bin(base + SIGN_CLASSES * (steps - 1),
                            (mag * (edge_d - pair_dist)) / step);
            end
        end
    endtask

    assign o_reads_pending = pending_reads.size();

    always @(posedge i_clk) begin
        t_bin_read rd, want;
        if (!i_rst_n) begin
            for (int i = 0; i < BINS; i++) bin_store[i] = 0;
            shadow_cfg.bin_width    = 15'd256;
            shadow_cfg.steps_in_use = 7'd12;
            shadow_cfg.max_clash    = 3'd2;
            shadow_cfg.root_mode    = 1'b0;
            pending_reads.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP_SIZE: shadow_cfg.bin_width    = i_cfg_data;
                    CFG_STEPS:     shadow_cfg.steps_in_use = i_cfg_data[6:0];
                    CFG_CLASH_MAX: shadow_cfg.max_clash    = i_cfg_data[2:0];
                    CFG_ROOT:      shadow_cfg.root_mode    = i_cfg_data[0];
                    default:       shadow_cfg.root_mode    = shadow_cfg.root_mode;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_READ) begin
                    rd.bin_number = s_axis_tdata[66:56];
                    rd.contents = 0;
                    if (rd.bin_number < BINS) begin
                        rd.contents = bin_store[rd.bin_number];
                        bin_store[rd.bin_number] = 0;
                    end
                    pending_reads.push_back(rd);
                end else begin
                    accumulate_pair(s_axis_tdata);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_reads.size() == 0) begin
                    $display("%0t: unexpected beat bin %0d contents %0h", $time,
                             m_axis_tdata[10:0], m_axis_tdata[50:11]);
                    o_fail_count++;
                end else begin
                    want = pending_reads.pop_front();
                    if (m_axis_tdata[10:0] !== want.bin_number) begin
                        $display("%0t: bin_number expected %0d actual %0d", $time,
                                 want.bin_number, m_axis_tdata[10:0]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[50:11] !== want.contents) begin
                        $display("%0t: bin_contents of bin %0d expected %0h actual %0h",
                                 $time, want.bin_number, want.contents, m_axis_tdata[50:11]);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// File: dv/smooth_rdf_histogram_accumulator_core_tb.sv
// testbench top for the histogram accumulator: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
module smooth_rdf_histogram_accumulator_core_tb;
    import srha_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_idx = CFG_STEP_SIZE;
    logic [14:0]           i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = CMD_ACC;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    fail_count;
    int                    reads_pending;
    int                    send_gap_pct = 6;
    int                    recv_stall_pct = 49;
    int                    cur_steps = 12;
    int                    cur_step = 256;

    smooth_rdf_histogram_accumulator_core dut (.*);

    smooth_rdf_histogram_accumulator_core_checker scoreboard (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_reads_pending(reads_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_beat(logic cmd, logic [15:0] pair_dist, logic [15:0] pa,
                             logic [15:0] pb, logic [7:0] clash, logic [10:0] ridx);
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, ridx, clash, pb, pa, pair_dist};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // block drains silently after the last read, so give it time before a write
    task automatic settle_and_configure(int step, int steps, int clash_max, int root);
        s_axis_tvalid <= 1'b0;
        while (reads_pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_STEP_SIZE; i_cfg_data <= 15'(step);
        @(posedge i_clk);
        i_cfg_idx <= CFG_STEPS; i_cfg_data <= 15'(steps);
        @(posedge i_clk);
        i_cfg_idx <= CFG_CLASH_MAX; i_cfg_data <= 15'(clash_max);
        @(posedge i_clk);
        i_cfg_idx <= CFG_ROOT; i_cfg_data <= 15'(root);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_step = (step == 0) ? 1 : step;
        cur_steps = (steps == 0) ? 1 : (steps > 64 ? 64 : steps);
    endtask

    function automatic logic [15:0] pick_property();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'(signed'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_beat(int clash_span);
        int edge_d, span;
        edge_d = cur_steps * cur_step + cur_step;
        span = cur_steps * SIGN_CLASSES * (clash_span + 1);
        if ($urandom_range(99) < 65) begin
            send_beat(CMD_ACC,
                      ($urandom_range(9) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, edge_d > 65535 ? 65535 : edge_d)),
                      pick_property(), pick_property(),
                      ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9)),
                      11'($urandom));
        end else begin
            send_beat(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                      ($urandom_range(9) == 0) ? 11'($urandom)
                                               : 11'($urandom_range(0, span > 2047 ? 2047 : span)));
        end
    endtask

    int phase_step [8]  = '{3, 25600, 100, 0, 32767, 500, 40, 1};
    int phase_steps [8] = '{64, 1, 20, 0, 127, 64, 8, 2};
    int phase_clash [8] = '{7, 0, 3, 7, 5, 1, 0, 4};
    int phase_root [8]  = '{1, 0, 1, 0, 1, 0, 1, 1};

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset configuration, property and distance extremes, bin edges
        send_beat(CMD_ACC, 16'd0, 16'h7FFF, 16'h7FFF, 8'd0, 11'd0);
        send_beat(CMD_ACC, 16'd384, 16'h8000, 16'h8000, 8'd1, 11'd0);
        send_beat(CMD_ACC, 16'd640, 16'h8000, 16'h7FFF, 8'd255, 11'd0);
        send_beat(CMD_ACC, 16'd100, 16'h0000, 16'h1234, 8'd0, 11'd0);
        send_beat(CMD_ACC, 16'd100, 16'h1234, 16'h0000, 8'd0, 11'd0);
        send_beat(CMD_ACC, 16'd2900, 16'h0100, 16'h0100, 8'd0, 11'd0);
        send_beat(CMD_ACC, 16'd3072, 16'h0100, 16'h0100, 8'd0, 11'd0);
        send_beat(CMD_ACC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd2, 11'd0);
        send_beat(CMD_ACC, 16'd2816, 16'hFF00, 16'hFF00, 8'd0, 11'd0);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd0);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd3);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd0);
        send_beat(CMD_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 11'd41);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd74);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd33);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd35);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd1535);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd1536);
        send_beat(CMD_READ, 16'd0, 16'd0, 16'd0, 8'd0, 11'd2047);

        for (int p = 0; p < 8; p++) begin
            settle_and_configure(phase_step[p], phase_steps[p], phase_clash[p], phase_root[p]);
            for (int n = 0; n < 130; n++) begin
                if (p * 130 + n == 350) begin
                    send_gap_pct = 49;
                    recv_stall_pct = 6;
                end else if (p * 130 + n == 700) begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                random_beat(phase_clash[p]);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (reads_pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && reads_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
